FILE: sv/bricked_volume_lod_brick_index_top_defines.svh
// Assertion macros shared by the brick index RTL.
// Included by the modules that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef BRICKED_VOLUME_LOD_BRICK_INDEX_TOP_DEFINES_SVH
`define BRICKED_VOLUME_LOD_BRICK_INDEX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BVLBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BVLBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/bvlbi_pkg.sv
// Types and constants for the bricked volume level-of-detail brick index block.
// No dependencies; imported by bricked_volume_lod_brick_index_top.
package bvlbi_pkg;

  localparam int EXT_W   = 16;  // volume extent and brick coordinate width
  localparam int EDGE_W  = 11;  // brick edge width, also the effective size width
  localparam int OVL_W   = 9;
  localparam int IDX_W   = 49;
  localparam int PLANE_W = 32;
  localparam int LOD_W   = 5;
  localparam int CFG_IDX_W = 3;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_VOL_W     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_H     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_D     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OVERLAP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_CNT = 3'd5;

  // Result error codes.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EFF   = 2'd1;
  localparam logic [1:0] ERR_LEVEL = 2'd2;
  localparam logic [1:0] ERR_RANGE = 2'd3;

  typedef struct packed {
    logic [LOD_W-1:0] lod_level;
    logic [EXT_W-1:0] brick_x;
    logic [EXT_W-1:0] brick_y;
    logic [EXT_W-1:0] brick_z;
  } bvlbi_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] brick_index;
    logic [1:0]       error_code;
  } bvlbi_out_t;

  // One row of the level table.
  typedef struct packed {
    logic [IDX_W-1:0]   prior;
    logic [EXT_W-1:0]   across;
    logic [PLANE_W-1:0] plane;
  } bvlbi_level_t;

endpackage

FILE: sv/bricked_volume_lod_brick_index_top.sv
// Brick index lookup for a bricked multi-resolution volume, with its level table builder.
// Depends on bvlbi_pkg and bricked_volume_lod_brick_index_top_defines.svh.
//
// Usage: geometry and the entry count are written on the cfg_ port (cfg_we, cfg_index,
// cfg_wdata) while the block is idle. Requests arrive as in_ beats (level, x, y, z) and
// each yields exactly one out_ beat carrying the brick index and an error code.
// The block handles one request at a time. A lookup steps through the check, read, sum and
// output states; a request that fails the size or level check skips the read and sum
// states. in_ready returns once the result register is loaded. The first request after a
// geometry write first rebuilds the level table in a single-port table memory: an init
// step, then per level the three bit-serial ceiling dividers running side by side, the
// multiply states MUL1 and MUL2 and a write step; a bad effective size skips the build.
// Reset restores the register defaults and marks the table stale; the table memory
// itself is never cleared, since no row is read before the build writes it.
// A stalled receiver holds the result in the output register while the next request
// is accepted and worked on; that request then waits in its last step until the output
// register frees up.
module bricked_volume_lod_brick_index_top
  import bvlbi_pkg::*;
#(
  parameter int MAX_LEVELS = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bvlbi_in_t            in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bvlbi_out_t           out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IDX_W-1:0]     cfg_wdata
);

`include "bricked_volume_lod_brick_index_top_defines.svh"

  localparam int AW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int TW    = $clog2(MAX_LEVELS + 1);
  localparam int CNT_W = $clog2(EXT_W);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_INIT  = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_MUL1  = 10'b00_0000_1000,
    S_MUL2  = 10'b00_0001_0000,
    S_WR    = 10'b00_0010_0000,
    S_CHECK = 10'b00_0100_0000,
    S_RD    = 10'b00_1000_0000,
    S_SUM   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  // Configuration registers.
  logic [EXT_W-1:0]  vol_w_r, vol_h_r, vol_d_r;
  logic [EDGE_W-1:0] edge_r;
  logic [OVL_W-1:0]  overlap_r;
  logic [IDX_W-1:0]  entry_cnt_r;

  state_t state_r, state_nxt;
  logic   table_ready_r, table_ready_nxt;
  logic [TW-1:0] level_total_r, level_total_nxt;
  logic [TW-1:0] target_r, target_nxt;
  logic [AW-1:0] build_lvl_r, build_lvl_nxt;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  // Three division lanes: x, y and z.
  logic [EXT_W-1:0]  ext_r [3];
  logic [EXT_W-1:0]  ext_nxt [3];
  logic [EXT_W-1:0]  num_r [3];
  logic [EXT_W-1:0]  num_nxt [3];
  logic [EXT_W-1:0]  quo_r [3];
  logic [EXT_W-1:0]  quo_nxt [3];
  logic [EDGE_W-1:0] rem_r [3];
  logic [EDGE_W-1:0] rem_nxt [3];
  logic [EXT_W-1:0]  bricks [3];

  logic [EDGE_W-1:0]  eff_r, eff_nxt;
  logic [IDX_W-1:0]   prior_r, prior_nxt;
  logic [PLANE_W-1:0] plane_r, plane_nxt;
  logic [IDX_W-2:0]   bvol_r, bvol_nxt;

  bvlbi_in_t    item_r, item_nxt;
  logic [1:0]   chk_err_r, chk_err_nxt;
  logic [PLANE_W-1:0] prod_y_r, prod_y_nxt;
  logic [IDX_W-2:0]   prod_z_r, prod_z_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic         out_valid_r, out_valid_nxt;
  bvlbi_out_t   out_data_r, out_data_nxt;

  bvlbi_level_t tbl_mem [MAX_LEVELS];
  bvlbi_level_t rd_q_r;
  bvlbi_level_t wr_entry;

  logic signed [EDGE_W+1:0] eff_s;
  logic        eff_bad;
  logic [EXT_W-1:0] max_bricks, max_m1;
  logic [5:0]  bit_len, lv_raw, lv_cap;
  logic [TW-1:0] lvl_inc, lvl_goal;
  logic        lvl_ok;
  logic        in_fire, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Effective brick size: edge minus overlap on both sides, signed.
  assign eff_s   = $signed({2'b00, edge_r}) - $signed({3'b000, overlap_r, 1'b0});
  assign eff_bad = eff_s[EDGE_W+1] || (eff_s == '0);

  assign lvl_ok = ({1'b0, item_r.lod_level} < 6'(level_total_r));

  // Ceiling counts from the finished division lanes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      bricks[i] = quo_r[i] + EXT_W'(rem_r[i] != '0);
    end
  end

  // Level count from the largest level 0 count: one plus the bit length of (max - 1), capped at MAX_LEVELS.
  always_comb begin
    max_bricks = bricks[0];
    if (bricks[1] > max_bricks) begin
      max_bricks = bricks[1];
    end
    if (bricks[2] > max_bricks) begin
      max_bricks = bricks[2];
    end
    max_m1  = max_bricks - EXT_W'(1);
    bit_len = '0;
    if (max_bricks > EXT_W'(1)) begin
      for (int i = 0; i < EXT_W; i++) begin
        if (max_m1[i]) begin
          bit_len = 6'(i + 1);
        end
      end
    end
    lv_raw = bit_len + 6'd1;
    lv_cap = (lv_raw > 6'(MAX_LEVELS)) ? 6'(MAX_LEVELS) : lv_raw;
  end

  assign lvl_inc  = TW'(build_lvl_r) + TW'(1);
  assign lvl_goal = (build_lvl_r == '0) ? TW'(lv_cap) : target_r;

  assign wr_entry.prior  = prior_r;
  assign wr_entry.across = bricks[0];
  assign wr_entry.plane  = plane_r;

  always_comb begin
    logic [EDGE_W:0] rem_sh;
    state_nxt       = state_r;
    table_ready_nxt = table_ready_r;
    level_total_nxt = level_total_r;
    target_nxt      = target_r;
    build_lvl_nxt   = build_lvl_r;
    div_cnt_nxt     = div_cnt_r;
    eff_nxt         = eff_r;
    prior_nxt       = prior_r;
    plane_nxt       = plane_r;
    bvol_nxt        = bvol_r;
    item_nxt        = item_r;
    chk_err_nxt     = chk_err_r;
    prod_y_nxt      = prod_y_r;
    prod_z_nxt      = prod_z_r;
    sum_nxt         = sum_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    rem_sh          = '0;
    for (int i = 0; i < 3; i++) begin
      ext_nxt[i] = ext_r[i];
      num_nxt[i] = num_r[i];
      quo_nxt[i] = quo_r[i];
      rem_nxt[i] = rem_r[i];
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          item_nxt  = in_data;
          state_nxt = table_ready_r ? S_CHECK : S_INIT;
        end
      end
      S_INIT: begin
        level_total_nxt = '0;
        prior_nxt       = '0;
        build_lvl_nxt   = '0;
        div_cnt_nxt     = '0;
        eff_nxt         = eff_s[EDGE_W-1:0];
        ext_nxt[0]      = vol_w_r;
        ext_nxt[1]      = vol_h_r;
        ext_nxt[2]      = vol_d_r;
        for (int i = 0; i < 3; i++) begin
          quo_nxt[i] = '0;
          rem_nxt[i] = '0;
        end
        num_nxt[0] = vol_w_r;
        num_nxt[1] = vol_h_r;
        num_nxt[2] = vol_d_r;
        if (eff_bad) begin
          table_ready_nxt = 1'b1;
          state_nxt       = S_CHECK;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One restoring division step per lane and cycle.
        for (int i = 0; i < 3; i++) begin
          rem_sh = {rem_r[i], num_r[i][EXT_W-1]};
          num_nxt[i] = {num_r[i][EXT_W-2:0], 1'b0};
          if (rem_sh >= {1'b0, eff_r}) begin
            rem_nxt[i] = EDGE_W'(rem_sh - {1'b0, eff_r});
            quo_nxt[i] = {quo_r[i][EXT_W-2:0], 1'b1};
          end else begin
            rem_nxt[i] = rem_sh[EDGE_W-1:0];
            quo_nxt[i] = {quo_r[i][EXT_W-2:0], 1'b0};
          end
        end
        div_cnt_nxt = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(EXT_W - 1)) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        plane_nxt = PLANE_W'(bricks[0] * bricks[1]);
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        bvol_nxt  = (IDX_W - 1)'(plane_r * bricks[2]);
        state_nxt = S_WR;
      end
      S_WR: begin
        prior_nxt = prior_r + IDX_W'(bvol_r);
        if (build_lvl_r == '0) begin
          target_nxt = TW'(lv_cap);
        end
        if (lvl_inc == lvl_goal) begin
          level_total_nxt = lvl_goal;
          table_ready_nxt = 1'b1;
          state_nxt       = S_CHECK;
        end else begin
          build_lvl_nxt = AW'(lvl_inc);
          div_cnt_nxt   = '0;
          for (int i = 0; i < 3; i++) begin
            ext_nxt[i] = ext_r[i] >> 1;
            num_nxt[i] = ext_r[i] >> 1;
            quo_nxt[i] = '0;
            rem_nxt[i] = '0;
          end
          state_nxt = S_DIV;
        end
      end
      S_CHECK: begin
        if (eff_bad) begin
          chk_err_nxt = ERR_EFF;
          state_nxt   = S_OUT;
        end else if (!lvl_ok) begin
          chk_err_nxt = ERR_LEVEL;
          state_nxt   = S_OUT;
        end else begin
          chk_err_nxt = ERR_OK;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        prod_y_nxt = PLANE_W'(item_r.brick_y * rd_q_r.across);
        prod_z_nxt = (IDX_W - 1)'(item_r.brick_z * rd_q_r.plane);
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        sum_nxt = SUM_W'(rd_q_r.prior) + SUM_W'(item_r.brick_x)
                + SUM_W'(prod_y_r) + SUM_W'(prod_z_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (chk_err_r != ERR_OK) begin
            out_data_nxt.brick_index = '0;
            out_data_nxt.error_code  = chk_err_r;
          end else if (sum_r >= {1'b0, entry_cnt_r}) begin
            out_data_nxt.brick_index = '0;
            out_data_nxt.error_code  = ERR_RANGE;
          end else begin
            out_data_nxt.brick_index = sum_r[IDX_W-1:0];
            out_data_nxt.error_code  = ERR_OK;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Any geometry write makes the table stale; the entry count does not.
    if (cfg_we && (cfg_index == REG_VOL_W || cfg_index == REG_VOL_H ||
                   cfg_index == REG_VOL_D || cfg_index == REG_EDGE ||
                   cfg_index == REG_OVERLAP)) begin
      table_ready_nxt = 1'b0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      table_ready_r <= 1'b0;
      level_total_r <= '0;
      out_valid_r   <= 1'b0;
      vol_w_r       <= EXT_W'(1);
      vol_h_r       <= EXT_W'(1);
      vol_d_r       <= EXT_W'(1);
      edge_r        <= EDGE_W'(64);
      overlap_r     <= '0;
      entry_cnt_r   <= '0;
    end else begin
      state_r       <= state_nxt;
      table_ready_r <= table_ready_nxt;
      level_total_r <= level_total_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_VOL_W:     vol_w_r     <= cfg_wdata[EXT_W-1:0];
          REG_VOL_H:     vol_h_r     <= cfg_wdata[EXT_W-1:0];
          REG_VOL_D:     vol_d_r     <= cfg_wdata[EXT_W-1:0];
          REG_EDGE:      edge_r      <= cfg_wdata[EDGE_W-1:0];
          REG_OVERLAP:   overlap_r   <= cfg_wdata[OVL_W-1:0];
          REG_ENTRY_CNT: entry_cnt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    target_r     <= target_nxt;
    build_lvl_r  <= build_lvl_nxt;
    div_cnt_r    <= div_cnt_nxt;
    eff_r        <= eff_nxt;
    prior_r      <= prior_nxt;
    plane_r      <= plane_nxt;
    bvol_r       <= bvol_nxt;
    item_r       <= item_nxt;
    chk_err_r    <= chk_err_nxt;
    prod_y_r     <= prod_y_nxt;
    prod_z_r     <= prod_z_nxt;
    sum_r        <= sum_nxt;
    out_data_r   <= out_data_nxt;
    for (int i = 0; i < 3; i++) begin
      ext_r[i] <= ext_nxt[i];
      num_r[i] <= num_nxt[i];
      quo_r[i] <= quo_nxt[i];
      rem_r[i] <= rem_nxt[i];
    end
  end

  // Level table: written once per level during a build, read once per lookup that passes the checks.
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      tbl_mem[build_lvl_r] <= wr_entry;
    end
    if (state_r == S_CHECK && !eff_bad && lvl_ok) begin
      rd_q_r <= tbl_mem[item_r.lod_level[AW-1:0]];
    end
  end

  `BVLBI_ASSERT_NEXT(a_one_beat_in_flight, in_fire, !in_ready,
                     "input taken while a request is still in flight")
  `BVLBI_ASSERT_NOW(a_lookup_after_build, state_r == S_CHECK, table_ready_r,
                    "lookup started on a stale level table")
  `BVLBI_ASSERT_NOW(a_write_in_range, state_r == S_WR, 32'(build_lvl_r) < MAX_LEVELS,
                    "level table write past its depth")
  `BVLBI_ASSERT_NOW(a_error_zero_index,
                    out_valid_r && out_data_r.error_code != ERR_OK,
                    out_data_r.brick_index == '0,
                    "nonzero brick index reported with an error")

endmodule

FILE: test/tb.sv
// Self-checking testbench for bricked_volume_lod_brick_index_top: directed geometry corners,
// then random register settings and lookup beats with random sender gaps and receiver stalls.
// Depends on bvlbi_pkg and the block's RTL; results are predicted by a scoreboard class.
module tb;
  import bvlbi_pkg::*;

  localparam int LOD_LEVELS     = 17;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 80;
  localparam int REPORT_LIMIT   = 10;

  // Indexes past the register map; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};
  localparam logic [EXT_W-1:0] EXT_MAX = {EXT_W{1'b1}};

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  class brick_index_scoreboard;
    bit [EXT_W-1:0]   vol_w = 1;
    bit [EXT_W-1:0]   vol_h = 1;
    bit [EXT_W-1:0]   vol_d = 1;
    bit [EDGE_W-1:0]  edge_len = 64;
    bit [OVL_W-1:0]   overlap = 0;
    bit [IDX_W-1:0]   entry_count = 0;
    bit [IDX_W-1:0]   prior_tab [LOD_LEVELS];
    bit [PLANE_W-1:0] plane_tab [LOD_LEVELS];
    bit [EXT_W-1:0]   cnt_x [LOD_LEVELS];
    bit [EXT_W-1:0]   cnt_y [LOD_LEVELS];
    bit [EXT_W-1:0]   cnt_z [LOD_LEVELS];
    int unsigned      level_count = 0;
    bit               table_valid = 0;
    bit [IDX_W-1:0]   brick_sum = 0;
    bvlbi_out_t       expected_q [$];
    int               failures = 0;

    function int eff_size();
      return int'(edge_len) - 2 * int'(overlap);
    endfunction

    function int unsigned bricks_along(int unsigned extent, int unsigned eff);
      return (extent + eff - 1) / eff;
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [IDX_W-1:0] value);
      case (idx)
        REG_VOL_W: begin
          vol_w = value[EXT_W-1:0];
          table_valid = 0;
        end
        REG_VOL_H: begin
          vol_h = value[EXT_W-1:0];
          table_valid = 0;
        end
        REG_VOL_D: begin
          vol_d = value[EXT_W-1:0];
          table_valid = 0;
        end
        REG_EDGE: begin
          edge_len = value[EDGE_W-1:0];
          table_valid = 0;
        end
        REG_OVERLAP: begin
          overlap = value[OVL_W-1:0];
          table_valid = 0;
        end
        REG_ENTRY_CNT: entry_count = value;
        default: ;
      endcase
    endfunction

    function void rebuild_levels();
      int          e;
      int unsigned w, h, d, m, v, lv, bx, by, bz;
      bit [63:0]   prior, plane;
      e = eff_size();
      prior = 0;
      level_count = 0;
      brick_sum = 0;
      table_valid = 1;
      if (e < 1) return;
      w = 32'(vol_w);
      h = 32'(vol_h);
      d = 32'(vol_d);
      m = bricks_along(w, e);
      if (bricks_along(h, e) > m) m = bricks_along(h, e);
      if (bricks_along(d, e) > m) m = bricks_along(d, e);
      lv = 1;
      if (m > 1) begin
        v = m - 1;
        while (v != 0) begin
          lv++;
          v >>= 1;
        end
      end
      if (lv > LOD_LEVELS) lv = LOD_LEVELS;
      for (int l = 0; l < lv; l++) begin
        bx = bricks_along(w, e);
        by = bricks_along(h, e);
        bz = bricks_along(d, e);
        plane = 64'(bx) * 64'(by);
        prior_tab[l] = prior[IDX_W-1:0];
        plane_tab[l] = plane[PLANE_W-1:0];
        cnt_x[l] = EXT_W'(bx);
        cnt_y[l] = EXT_W'(by);
        cnt_z[l] = EXT_W'(bz);
        prior = (prior + plane * 64'(bz)) & 64'(IDX_MAX);
        w >>= 1;
        h >>= 1;
        d >>= 1;
      end
      level_count = lv;
      brick_sum = prior[IDX_W-1:0];
    endfunction

    function bit [IDX_W-1:0] total_bricks();
      if (!table_valid) rebuild_levels();
      return brick_sum;
    endfunction

    function void note_request(bvlbi_in_t req);
      bvlbi_out_t  res;
      bit [63:0]   idx;
      int unsigned lvl;
      if (!table_valid) rebuild_levels();
      lvl = 32'(req.lod_level);
      res.brick_index = '0;
      if (eff_size() < 1) begin
        res.error_code = ERR_EFF;
      end else if (lvl >= level_count) begin
        res.error_code = ERR_LEVEL;
      end else begin
        // Coordinates are not range checked; only the entry count bounds the index.
        idx = 64'(prior_tab[lvl]) + 64'(req.brick_x)
            + 64'(req.brick_y) * 64'(cnt_x[lvl])
            + 64'(req.brick_z) * 64'(plane_tab[lvl]);
        if (idx >= 64'(entry_count)) begin
          res.error_code = ERR_RANGE;
        end else begin
          res.error_code = ERR_OK;
          res.brick_index = idx[IDX_W-1:0];
        end
      end
      expected_q = {expected_q, res};
    endfunction

    function void check_result(bvlbi_out_t got);
      bvlbi_out_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected result beat: index %0d error %0d",
                   got.brick_index, got.error_code);
        return;
      end
      want = expected_q.pop_front();
      if (got.brick_index !== want.brick_index || got.error_code !== want.error_code) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("mismatch: expected index %0d error %0d, got index %0d error %0d",
                   want.brick_index, want.error_code, got.brick_index, got.error_code);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  bvlbi_in_t            in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bvlbi_out_t           out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [IDX_W-1:0]     cfg_wdata = '0;

  brick_index_scoreboard sb = new();

  bricked_volume_lod_brick_index_top #(
    .MAX_LEVELS(LOD_LEVELS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: switches between always ready, random stalls and a fixed stall rhythm.
  rx_mode_t rx_mode = RX_ALWAYS;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(30, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
      default:   out_ready <= ((rx_tick % 13) < 5);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) sb.check_result(out_data);
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("bricked_volume_lod_brick_index_top regression: fail");
      $finish;
    end
  end

  function automatic bvlbi_in_t req_of(int unsigned lvl, int unsigned x, int unsigned y,
                                       int unsigned z);
    bvlbi_in_t req;
    req.lod_level = LOD_W'(lvl);
    req.brick_x = EXT_W'(x);
    req.brick_y = EXT_W'(y);
    req.brick_z = EXT_W'(z);
    return req;
  endfunction

  // Mostly lookups inside the current level table; the rest is random noise.
  function automatic bvlbi_in_t pick_lookup();
    bvlbi_in_t   req;
    int unsigned lvl;
    if (sb.level_count > 0 && $urandom_range(0, 99) < 75) begin
      lvl = $urandom_range(0, sb.level_count - 1);
      req.lod_level = LOD_W'(lvl);
      req.brick_x = (sb.cnt_x[lvl] > 0) ? EXT_W'($urandom_range(0, sb.cnt_x[lvl] - 1)) : '0;
      req.brick_y = (sb.cnt_y[lvl] > 0) ? EXT_W'($urandom_range(0, sb.cnt_y[lvl] - 1)) : '0;
      req.brick_z = (sb.cnt_z[lvl] > 0) ? EXT_W'($urandom_range(0, sb.cnt_z[lvl] - 1)) : '0;
    end else begin
      if ($urandom_range(0, 1) != 0 || sb.level_count == 0)
        req.lod_level = LOD_W'($urandom_range(0, 31));
      else
        req.lod_level = LOD_W'($urandom_range(0, sb.level_count - 1));
      req.brick_x = EXT_W'($urandom_range(0, 65535));
      req.brick_y = EXT_W'($urandom_range(0, 65535));
      req.brick_z = EXT_W'($urandom_range(0, 65535));
    end
    return req;
  endfunction

  function automatic bit [EXT_W-1:0] pick_extent();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return EXT_W'($urandom_range(1, 200));
    if (r < 82) return EXT_W'($urandom_range(1, 65535));
    if (r < 94) return EXT_W'($urandom_range(0, 3));
    return EXT_MAX;
  endfunction

  // Leaves cfg_we high; the caller lowers it after the last write of a batch.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [IDX_W-1:0] value, input bit junk);
    logic [IDX_W-1:0] word, keep;
    case (idx)
      REG_VOL_W, REG_VOL_H, REG_VOL_D: keep = IDX_W'({EXT_W{1'b1}});
      REG_EDGE:    keep = IDX_W'({EDGE_W{1'b1}});
      REG_OVERLAP: keep = IDX_W'({OVL_W{1'b1}});
      default:     keep = IDX_MAX;
    endcase
    word = value;
    if (junk) word = (IDX_W'({$urandom, $urandom}) & ~keep) | (value & keep);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= word;
    @(posedge clk);
    sb.apply_register(idx, word);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned d,
                              input int unsigned edge_w, input int unsigned ovl,
                              input logic [IDX_W-1:0] entries);
    write_register(REG_VOL_W, IDX_W'(w), 1'b0);
    write_register(REG_VOL_H, IDX_W'(h), 1'b0);
    write_register(REG_VOL_D, IDX_W'(d), 1'b0);
    write_register(REG_EDGE, IDX_W'(edge_w), 1'b0);
    write_register(REG_OVERLAP, IDX_W'(ovl), 1'b0);
    write_register(REG_ENTRY_CNT, entries, 1'b0);
    cfg_we <= 1'b0;
  endtask

  // Valid stays high after the beat; the caller lowers it when a gap follows.
  task automatic send_request(input bvlbi_in_t req);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(req);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic run_random_phase();
    bit [EDGE_W-1:0] e;
    bit [OVL_W-1:0]  o;
    bit [IDX_W-1:0]  total, entries;
    int unsigned     r, k;
    int              sent, burst, gap, pause_at;
    bit              junk;
    junk = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 60)      e = EDGE_W'($urandom_range(1, 48));
    else if (r < 75) e = EDGE_W'($urandom_range(49, 1024));
    else if (r < 85) e = EDGE_W'(1024);
    else if (r < 92) e = EDGE_W'(1);
    else             e = EDGE_W'($urandom_range(0, 2047));
    r = $urandom_range(0, 99);
    if (r < 60)      o = OVL_W'($urandom_range(0, (e > 1) ? (e - 1) / 2 : 0));
    else if (r < 80) o = '0;
    else if (r < 90) o = OVL_W'(511);
    else             o = OVL_W'($urandom_range(0, 511));
    write_register(REG_VOL_W, IDX_W'(pick_extent()), junk);
    write_register(REG_VOL_H, IDX_W'(pick_extent()), junk);
    write_register(REG_VOL_D, IDX_W'(pick_extent()), junk);
    write_register(REG_EDGE, IDX_W'(e), junk);
    write_register(REG_OVERLAP, IDX_W'(o), junk);
    if ($urandom_range(0, 3) == 0)
      write_register($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                     IDX_W'({$urandom, $urandom}), 1'b0);
    total = sb.total_bricks();
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 20);
    if (r < 45)      entries = total;
    else if (r < 65) entries = (total > IDX_W'(k)) ? total - IDX_W'(k) : '0;
    else if (r < 80) entries = total + IDX_W'($urandom_range(0, 3));
    else if (r < 90) entries = IDX_W'({$urandom, $urandom});
    else             entries = IDX_MAX;
    write_register(REG_ENTRY_CNT, entries, 1'b0);
    cfg_we <= 1'b0;

    pause_at = $urandom_range(PHASE_ITEMS / 4, 3 * PHASE_ITEMS / 4);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
        // Once per phase the sender holds back until the block has drained.
        if (sent == pause_at) wait_drained();
        send_request(pick_lookup());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry with an empty brick table: every valid level is out of range.
    send_request(req_of(0, 0, 0, 0));
    send_request(req_of(1, 0, 0, 0));
    send_request(req_of(31, EXT_MAX, EXT_MAX, EXT_MAX));
    wait_drained();

    // Overlap leaves no usable brick interior.
    set_geometry(EXT_MAX, EXT_MAX, EXT_MAX, 2, 1, IDX_MAX);
    send_request(req_of(0, 0, 0, 0));
    send_request(req_of(31, EXT_MAX, EXT_MAX, EXT_MAX));
    wait_drained();

    // One-voxel bricks over the largest volume fill the level table; the top level is empty.
    set_geometry(EXT_MAX, EXT_MAX, EXT_MAX, 1, 0, IDX_MAX);
    send_request(req_of(0, 0, 0, 0));
    send_request(req_of(0, EXT_MAX, EXT_MAX, EXT_MAX));
    send_request(req_of(16, EXT_MAX, 0, 0));
    send_request(req_of(LOD_LEVELS, 0, 0, 0));
    send_request(req_of(15, 0, 0, 0));
    wait_drained();

    // Entry count alone does not rebuild; the last level 0 brick now falls outside.
    write_register(REG_ENTRY_CNT, 49'd281462092005374, 1'b0);
    cfg_we <= 1'b0;
    send_request(req_of(0, EXT_MAX, EXT_MAX, EXT_MAX));
    send_request(req_of(0, EXT_MAX - 1, EXT_MAX, EXT_MAX));
    wait_drained();

    // Zero width gives empty planes on every level.
    set_geometry(0, 1, EXT_MAX, 1024, 511, 49'd1000);
    send_request(req_of(0, 0, 0, 5));
    send_request(req_of(15, 0, 0, 0));
    send_request(req_of(16, 0, 0, 0));
    send_request(req_of(0, 3, 0, 0));
    wait_drained();

    write_register(REG_UNMAPPED_LO, IDX_MAX, 1'b0);
    write_register(REG_UNMAPPED_HI, IDX_MAX, 1'b0);
    cfg_we <= 1'b0;
    send_request(req_of(0, 7, 0, 0));
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) run_random_phase();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("bricked_volume_lod_brick_index_top regression: pass");
    else
      $display("bricked_volume_lod_brick_index_top regression: fail");
    $finish;
  end

endmodule
